FILE: sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Width of a stored element
    localparam int DATA_W = 32;

    // Most results a single dump item may produce
    localparam int MAX_RESULTS = 16;

    // Operation codes carried by an input item
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control states
    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DATA = 1'b1
    } state_t;

endpackage

`default_nettype wire

FILE: sv/deq_if.sv
// Handshake channels for command items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface deq_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last_flag;

    modport source (output valid, output out_value, output status, output last_flag,
                    input ready);
    modport sink   (input valid, input out_value, input status, input last_flag,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/double_ended_queue.sv
// Bounded double-ended queue held in a circular single-port-read memory.
//
//   channel  dir  payload                          accepted when
//   cmd      in   opcode, push_value               cmd.valid && cmd.ready
//   rsp      out  out_value, status, last_flag     rsp.valid && rsp.ready
//
// Push, clear, full/empty answers: the result register is loaded directly from the accepted item.
// Pop: a memory read into the read-data register, then the result register.
// Dump: min(count, 16) results, one memory read per element.
// Reset clears front index, count and control state; memory contents are kept.
// A stalled rsp holds the result register and blocks further reads and items.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Circular index helpers
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
        return (a == '0) ? IDX_W'(DEPTH - 1) : a - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic [IDX_W-1:0]     walk_reg, walk_next;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_value_reg;
    status_t              out_status_reg;
    logic                 out_last_reg;

    logic [DATA_W-1:0]    store_mem [DEPTH];
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    logic                 accept;
    logic                 slot_free;
    logic                 is_full;
    logic                 is_empty;
    logic                 out_load;
    logic [DATA_W-1:0]    ld_value;
    status_t              ld_status;
    logic                 ld_last;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // Decode the item, plan memory accesses and walk dump reads
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        walk_next   = walk_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        out_load    = 1'b0;
        ld_value    = '0;
        ld_status   = ST_OK;
        ld_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(cmd.opcode))
                        OP_PUSH_FRONT:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                ld_status = ST_FULL;
                            end
                            else
                            begin
                                front_next = idx_dec(front_reg);
                                wr_en      = 1'b1;
                                wr_addr    = idx_dec(front_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                ld_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = idx_add(front_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg;
                                front_next  = idx_inc(front_reg);
                                count_next  = count_reg - 1'b1;
                                remain_next = '0;
                                state_next  = S_DATA;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = idx_add(front_reg, count_reg - 1'b1);
                                count_next  = count_reg - 1'b1;
                                remain_next = '0;
                                state_next  = S_DATA;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en     = 1'b1;
                                rd_addr   = front_reg;
                                walk_next = front_reg;
                                if (int'(count_reg) > MAX_RESULTS)
                                begin
                                    remain_next = CNT_W'(MAX_RESULTS - 1);
                                end
                                else
                                begin
                                    remain_next = count_reg - 1'b1;
                                end
                                state_next = S_DATA;
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_load   = 1'b1;
                            count_next = '0;
                            front_next = '0;
                        end
                        default:
                        begin
                            // Unknown code: drop the item without a result
                        end
                    endcase
                end
            end
            S_DATA:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    ld_value = rd_data_reg;
                    ld_last  = (remain_reg == '0);
                    if (remain_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                        walk_next   = idx_inc(walk_reg);
                        rd_en       = 1'b1;
                        rd_addr     = idx_inc(walk_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold queue pointers and dump walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
            walk_reg   <= '0;
        end
        else
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            walk_reg   <= walk_next;
        end
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= cmd.push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Result register: load a new item or drop the one taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= ld_value;
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.last_flag = out_last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("element count exceeds depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(front_reg) < DEPTH)
        else $error("front index out of range");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> !wr_en)
        else $error("memory write while reading out elements");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten before taken");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_reg != '0 &&
         (cmd.opcode == OP_POP_FRONT || cmd.opcode == OP_POP_BACK))
        |=> (state_reg == S_DATA && remain_reg == '0))
        else $error("pop did not enter single-element readout");

endmodule

`default_nettype wire
